@@ hdl/web_flow_feature_histogram_top_defines.svh @@
// Assertion macros shared by the checker files of the flow feature histogram.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WEB_FLOW_FEATURE_HISTOGRAM_TOP_DEFINES_SVH
`define WEB_FLOW_FEATURE_HISTOGRAM_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFFH_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ hdl/wffh_pkg.sv @@
package wffh_pkg;

	// Widths of the counters and of the time arithmetic.
	localparam int COUNTER_WIDTH   = 32;
	localparam int TIMESTAMP_WIDTH = 48;
	localparam int CFG_WIDTH       = 32;
	localparam int CFG_IDX_WIDTH   = 1;
	localparam int SEG_LEN_WIDTH   = 32;

	// Counter layout: per direction one count, 22 size bins and 8 time bins.
	localparam int NUM_COUNTERS    = 62;
	localparam int DIR_STRIDE      = 31;
	localparam int OFF_SIZE_FIRST  = 1;
	localparam int OFF_TIME_FIRST  = 23;
	localparam int SIZE_BINS       = 22;
	localparam int TIME_BINS       = 8;
	localparam int COUNT_DEPTH     = 2;
	localparam int SIZE_DEPTH      = 2 * SIZE_BINS;
	localparam int TIME_DEPTH      = 2 * TIME_BINS;
	localparam int COUNT_AW        = $clog2(COUNT_DEPTH);
	localparam int SIZE_AW         = $clog2(SIZE_DEPTH);
	localparam int TIME_AW         = $clog2(TIME_DEPTH);

	// Result codes for "no bin".
	localparam logic [4:0] SIZE_NONE = 5'd22;
	localparam logic [4:0] TIME_NONE = 5'd16;
	localparam logic [3:0] BIN_NONE  = 4'd8;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_WIDTH-1:0] REG_GROUP_TIME    = 1'b0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_RESPONSE_TIME = 1'b1;
	localparam logic [CFG_WIDTH-1:0]     GROUP_TIME_RESET    = 32'd5000000;
	localparam logic [CFG_WIDTH-1:0]     RESPONSE_TIME_RESET = 32'd5000000;

	// Bin upper bounds (exclusive): bytes and microseconds.
	localparam int NUM_SIZE_BOUNDS = 21;
	localparam logic [31:0] SIZE_BOUNDS [NUM_SIZE_BOUNDS] = '{
		32'd50, 32'd100, 32'd150, 32'd200, 32'd300, 32'd400, 32'd500,
		32'd600, 32'd700, 32'd800, 32'd900, 32'd1000, 32'd1200, 32'd1400,
		32'd1600, 32'd1800, 32'd2000, 32'd3000, 32'd4000, 32'd5000, 32'd10000
	};
	localparam logic [31:0] TIME_BOUNDS [TIME_BINS] = '{
		32'd10000, 32'd50000, 32'd100000, 32'd200000,
		32'd500000, 32'd1000000, 32'd2500000, 32'd5000000
	};

	typedef logic [COUNTER_WIDTH-1:0]   cnt_t;
	typedef logic [TIMESTAMP_WIDTH-1:0] ts_t;

	typedef enum logic [1:0] {
		CMD_PACKET = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SEG_EMPTY = 2'd0,
		SEG_TLS   = 2'd1,
		SEG_SKIP  = 2'd2
	} seg_state_t;

	typedef enum logic [1:0] {
		CS_NONE = 2'd0,
		CS_ASK  = 2'd1,
		CS_RESP = 2'd2
	} conn_state_t;

	typedef enum logic [1:0] {
		BANK_COUNT = 2'd0,
		BANK_SIZE  = 2'd1,
		BANK_TIME  = 2'd2
	} bank_t;

	// One input transaction.
	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] payload_len;
		logic        push_req;
		logic        tls_app_start;
		logic [47:0] timestamp_us;
		logic [5:0]  counter_index;
	} wffh_in_t;

	// One result transaction.
	typedef struct packed {
		logic        accepted;
		logic        direction;
		logic [4:0]  size_bin;
		logic [4:0]  time_bin;
		logic [1:0]  conn_state;
		logic [31:0] read_data;
	} wffh_out_t;

	// Decoded first-stage result handed to the counter stage.
	typedef struct packed {
		logic               accepted;
		logic               direction;
		logic [4:0]         size_bin;
		logic [4:0]         time_bin;
		logic [1:0]         conn_state;
		logic               clear_all;
		logic               rd_valid;
		bank_t              rd_bank;
		logic               count_inc;
		logic               size_inc;
		logic               time_inc;
		logic [COUNT_AW-1:0] count_addr;
		logic [SIZE_AW-1:0]  size_addr;
		logic [TIME_AW-1:0]  time_addr;
	} wffh_s1_t;

	// Size bin of a segment length; 21 for lengths at or above the last bound.
	function automatic logic [4:0] size_bin_of(input logic [SEG_LEN_WIDTH-1:0] len);
		logic [4:0] b;
		b = 5'(NUM_SIZE_BOUNDS);
		for (int i = NUM_SIZE_BOUNDS - 1; i >= 0; i--) begin
			if (len < SIZE_BOUNDS[i]) begin
				b = 5'(i);
			end
		end
		return b;
	endfunction

	// Time bin of a gap; a negative gap goes to the first bin, BIN_NONE when too long.
	function automatic logic [3:0] time_bin_of(input logic neg, input ts_t gap);
		logic [3:0] b;
		b = BIN_NONE;
		for (int i = TIME_BINS - 1; i >= 0; i--) begin
			if (gap < ts_t'(TIME_BOUNDS[i])) begin
				b = 4'(i);
			end
		end
		if (neg) begin
			b = '0;
		end
		return b;
	endfunction

	// Floor of the mean of two times without overflow.
	function automatic ts_t avg_ts(input ts_t a, input ts_t b);
		return (a >> 1) + (b >> 1) + ts_t'(a[0] & b[0]);
	endfunction

	// Counter increment that sticks at all ones.
	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

endpackage

@@ hdl/wffh_cfg_if.sv @@
// Configuration write channel: register index and data.
interface wffh_cfg_if import wffh_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_WIDTH-1:0] index;
	logic [CFG_WIDTH-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/wffh_in_if.sv @@
// Input channel carrying one command or packet per transaction.
interface wffh_in_if import wffh_pkg::*; ();
	logic     valid;
	logic     ready;
	wffh_in_t payload;

	modport source(output valid, payload, input ready);
	modport sink(input valid, payload, output ready);
endinterface

@@ hdl/wffh_out_if.sv @@
// Result channel carrying one result per transaction.
interface wffh_out_if import wffh_pkg::*; ();
	logic      valid;
	logic      ready;
	wffh_out_t payload;

	modport source(output valid, payload, input ready);
	modport sink(input valid, payload, output ready);
endinterface

@@ hdl/wffh_ram.sv @@
// Counter bank: one write port, one registered read port with write forwarding.
// Per-entry valid bits make unwritten or cleared entries read as zero.
module wffh_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	// Storage and registered read; a same-cycle write to the read address is forwarded.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else if (vld_q[raddr]) begin
				rdata <= mem[raddr];
			end else begin
				rdata <= '0;
			end
		end
	end

	// Valid bits: cleared at once by reset or a clear, set by a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

endmodule

@@ hdl/wffh_flow.sv @@
// First stage: segment tracking, asking/responding state, bin selection and
// counter addressing for one transaction. Flow state updates when the stage advances.
module wffh_flow import wffh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  wffh_in_t             item,
	input  logic [CFG_WIDTH-1:0] grp_gap_max,
	input  logic [CFG_WIDTH-1:0] rsp_gap_max,
	output wffh_s1_t             res
);

	seg_state_t               seg_state_q [2];
	logic [SEG_LEN_WIDTH-1:0] seg_len_q [2];
	conn_state_t              conn_q;
	ts_t                      asked_q;
	ts_t                      resp_q;
	ts_t                      lastq_q;

	seg_state_t               seg_state_n;
	logic [SEG_LEN_WIDTH-1:0] seg_len_n;
	conn_state_t              conn_n;
	ts_t                      asked_n;
	ts_t                      resp_n;
	ts_t                      lastq_n;

	ts_t                      ts;
	logic                     up;
	logic [SEG_LEN_WIDTH:0]   len_sum;
	logic [SEG_LEN_WIDTH-1:0] len_sat;
	logic                     take;
	logic                     finish;
	logic [4:0]               sbin;

	ts_t                      ask_gap;
	logic                     ask_new_group;
	ts_t                      q_gap;
	logic                     q_neg;
	logic                     q_binned;
	logic [3:0]               q_bin;
	ts_t                      ts_resp_gap;
	logic                     resp_avg_ok;
	ts_t                      rsp_gap;
	logic                     rsp_neg;
	logic                     rsp_binned;
	logic [3:0]               rsp_bin;

	logic                     rdir;
	logic [4:0]               rd_off;

	// Direction, saturating segment length and the size bin it falls into.
	assign ts      = ts_t'(item.timestamp_us);
	assign up      = item.src_port > item.dst_port;
	assign len_sum = {1'b0, seg_len_q[up]} + (SEG_LEN_WIDTH + 1)'(item.payload_len);
	assign len_sat = len_sum[SEG_LEN_WIDTH] ? '1 : len_sum[SEG_LEN_WIDTH-1:0];
	assign sbin    = size_bin_of(len_sat);

	// Gap tests on the stored times, computed side by side and selected below.
	assign ask_gap       = ts - asked_q;
	assign ask_new_group = (ts > asked_q) && (ask_gap > ts_t'(grp_gap_max));
	assign q_neg         = asked_q < lastq_q;
	assign q_gap         = asked_q - lastq_q;
	assign q_binned      = (lastq_q != '0) && (q_neg || (q_gap < ts_t'(grp_gap_max)));
	assign q_bin         = time_bin_of(q_neg, q_gap);
	assign ts_resp_gap   = ts - resp_q;
	assign resp_avg_ok   = (ts < resp_q) || (ts_resp_gap < ts_t'(rsp_gap_max));
	assign rsp_neg       = resp_q < asked_q;
	assign rsp_gap       = resp_q - asked_q;
	assign rsp_binned    = rsp_neg || (rsp_gap < ts_t'(rsp_gap_max));
	assign rsp_bin       = time_bin_of(rsp_neg, rsp_gap);

	// Counter index split for reads: direction half and offset within it.
	assign rdir   = item.counter_index >= 6'(DIR_STRIDE);
	assign rd_off = rdir ? 5'(item.counter_index - 6'(DIR_STRIDE)) : 5'(item.counter_index);

	// Command decode and next flow state.
	always_comb begin
		seg_state_n = seg_state_q[up];
		seg_len_n   = seg_len_q[up];
		conn_n      = conn_q;
		asked_n     = asked_q;
		resp_n      = resp_q;
		lastq_n     = lastq_q;
		take        = 1'b0;
		finish      = 1'b0;

		res            = '0;
		res.size_bin   = SIZE_NONE;
		res.time_bin   = TIME_NONE;
		res.rd_bank    = BANK_COUNT;

		unique case (item.command)
			CMD_READ: begin
				res.rd_valid = item.counter_index < 6'(NUM_COUNTERS);
				res.count_addr = COUNT_AW'(rdir);
				res.size_addr = SIZE_AW'(int'(rdir) * SIZE_BINS + int'(rd_off) - OFF_SIZE_FIRST);
				res.time_addr = TIME_AW'(int'(rdir) * TIME_BINS + int'(rd_off) - OFF_TIME_FIRST);
				priority if (rd_off == '0) begin
					res.rd_bank = BANK_COUNT;
				end else if (rd_off < 5'(OFF_TIME_FIRST)) begin
					res.rd_bank = BANK_SIZE;
				end else begin
					res.rd_bank = BANK_TIME;
				end
			end
			CMD_CLEAR: begin
				res.clear_all = 1'b1;
				conn_n = CS_NONE;
			end
			CMD_PACKET: begin
				res.direction = up;
				if (item.payload_len != '0) begin
					seg_len_n = len_sat;
					unique case (seg_state_q[up])
						SEG_EMPTY: begin
							if (item.tls_app_start) begin
								seg_state_n = SEG_TLS;
								take = item.push_req;
							end else begin
								seg_state_n = SEG_SKIP;
							end
						end
						SEG_TLS: begin
							take = item.push_req;
						end
						default: begin
							finish = item.push_req;
						end
					endcase

					if (take) begin
						res.accepted   = 1'b1;
						res.count_inc  = 1'b1;
						res.count_addr = COUNT_AW'(up);

						// Asking/responding machine.
						unique case (conn_q)
							CS_ASK: begin
								if (up) begin
									asked_n = ask_new_group ? ts : avg_ts(asked_q, ts);
								end else begin
									if (q_binned && (q_bin != BIN_NONE)) begin
										res.time_inc  = 1'b1;
										res.time_bin  = 5'(q_bin);
										res.time_addr = TIME_AW'(TIME_BINS + int'(q_bin));
									end
									lastq_n = asked_q;
									conn_n  = CS_RESP;
									resp_n  = ts;
								end
							end
							CS_RESP: begin
								if (!up) begin
									if (resp_avg_ok) begin
										resp_n = avg_ts(resp_q, ts);
									end
								end else begin
									if (rsp_binned && (rsp_bin != BIN_NONE)) begin
										res.time_inc  = 1'b1;
										res.time_bin  = 5'(TIME_BINS + int'(rsp_bin));
										res.time_addr = TIME_AW'(rsp_bin);
									end
									conn_n  = CS_ASK;
									asked_n = ts;
								end
							end
							default: begin
								if (up) begin
									asked_n = ts;
									conn_n  = CS_ASK;
								end else begin
									resp_n = ts;
									conn_n = CS_RESP;
								end
							end
						endcase

						res.size_inc  = 1'b1;
						res.size_bin  = sbin;
						res.size_addr = SIZE_AW'(int'(up) * SIZE_BINS + int'(sbin));
						finish = 1'b1;
					end

					if (finish) begin
						seg_len_n   = '0;
						seg_state_n = SEG_EMPTY;
					end
				end
			end
			default: begin
			end
		endcase

		res.conn_state = conn_n;
	end

	// Flow state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				seg_state_q[i] <= SEG_EMPTY;
				seg_len_q[i]   <= '0;
			end
			conn_q  <= CS_NONE;
			asked_q <= '0;
			resp_q  <= '0;
			lastq_q <= '0;
		end else if (advance) begin
			if (res.clear_all) begin
				for (int i = 0; i < 2; i++) begin
					seg_state_q[i] <= SEG_EMPTY;
					seg_len_q[i]   <= '0;
				end
				conn_q  <= CS_NONE;
				asked_q <= '0;
				resp_q  <= '0;
				lastq_q <= '0;
			end else begin
				seg_state_q[up] <= seg_state_n;
				seg_len_q[up]   <= seg_len_n;
				conn_q          <= conn_n;
				asked_q         <= asked_n;
				resp_q          <= resp_n;
				lastq_q         <= lastq_n;
			end
		end
	end

endmodule

@@ hdl/web_flow_feature_histogram_top.sv @@
// Channel | Role   | Transaction payload
// cfg     | sink   | index (register number), data (32-bit register value)
// pkt     | sink   | command, ports, payload_len, push_req, tls_app_start, timestamp_us,
//         |        | counter_index
// res     | source | accepted, direction, size_bin, time_bin, conn_state, read_data
//
// One transaction per cycle sustained while results are taken; an accepted input transaction
// passes the input register, the stage two register and the output register to the output.
// Stage one decodes and updates flow state and reads the counter banks; stage two
// increments and writes back, with forwarding between back-to-back transactions.
// Reset and the clear command empty all counters at once through per-entry valid bits.
// The output register holds a stalled result; up to two more inputs are taken meanwhile.
module web_flow_feature_histogram_top import wffh_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	wffh_cfg_if.sink    cfg,
	wffh_in_if.sink     pkt,
	wffh_out_if.source  res
);

	logic [CFG_WIDTH-1:0] group_q;
	logic [CFG_WIDTH-1:0] resp_time_q;

	logic      valid_s1;
	wffh_in_t  item_s1;
	logic      valid_s2;
	wffh_s1_t  info_s2;
	logic      out_valid_q;
	wffh_out_t out_q;

	wffh_s1_t  flow_res;
	logic      out_free;
	logic      move_s2;
	logic      free_s2;
	logic      move_s1;

	cnt_t      count_rd;
	cnt_t      size_rd;
	cnt_t      time_rd;
	cnt_t      count_nx;
	cnt_t      size_nx;
	cnt_t      time_nx;
	cnt_t      rd_sel;

	// Configuration registers; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q     <= GROUP_TIME_RESET;
			resp_time_q <= RESPONSE_TIME_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_GROUP_TIME) begin
				group_q <= cfg.data;
			end else if (cfg.index == REG_RESPONSE_TIME) begin
				resp_time_q <= cfg.data;
			end
		end
	end

	// Pipeline flow control.
	assign out_free  = !out_valid_q || res.ready;
	assign move_s2   = valid_s2 && out_free;
	assign free_s2   = !valid_s2 || move_s2;
	assign move_s1   = valid_s1 && free_s2;
	assign pkt.ready = !valid_s1 || move_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			item_s1 <= pkt.payload;
		end
	end

	wffh_flow u_flow (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (move_s1),
		.item        (item_s1),
		.grp_gap_max (group_q),
		.rsp_gap_max (resp_time_q),
		.res         (flow_res)
	);

	// Stage two register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= move_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			info_s2 <= flow_res;
		end
	end

	// Counter banks: per-direction counts, size bins and time bins.
	wffh_ram #(.DEPTH(COUNT_DEPTH), .WIDTH(COUNTER_WIDTH)) u_count_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (move_s1 && flow_res.clear_all),
		.re     (move_s1),
		.raddr  (flow_res.count_addr),
		.rdata  (count_rd),
		.we     (move_s2 && info_s2.count_inc),
		.waddr  (info_s2.count_addr),
		.wdata  (count_nx)
	);

	wffh_ram #(.DEPTH(SIZE_DEPTH), .WIDTH(COUNTER_WIDTH)) u_size_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (move_s1 && flow_res.clear_all),
		.re     (move_s1),
		.raddr  (flow_res.size_addr),
		.rdata  (size_rd),
		.we     (move_s2 && info_s2.size_inc),
		.waddr  (info_s2.size_addr),
		.wdata  (size_nx)
	);

	wffh_ram #(.DEPTH(TIME_DEPTH), .WIDTH(COUNTER_WIDTH)) u_time_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (move_s1 && flow_res.clear_all),
		.re     (move_s1),
		.raddr  (flow_res.time_addr),
		.rdata  (time_rd),
		.we     (move_s2 && info_s2.time_inc),
		.waddr  (info_s2.time_addr),
		.wdata  (time_nx)
	);

	// Saturating increments and read selection.
	assign count_nx = sat_inc(count_rd);
	assign size_nx  = sat_inc(size_rd);
	assign time_nx  = sat_inc(time_rd);

	always_comb begin
		unique case (info_s2.rd_bank)
			BANK_COUNT: rd_sel = count_rd;
			BANK_SIZE:  rd_sel = size_rd;
			BANK_TIME:  rd_sel = time_rd;
			default:    rd_sel = '0;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s2) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			out_q.accepted   <= info_s2.accepted;
			out_q.direction  <= info_s2.direction;
			out_q.size_bin   <= info_s2.size_bin;
			out_q.time_bin   <= info_s2.time_bin;
			out_q.conn_state <= info_s2.conn_state;
			out_q.read_data  <= info_s2.rd_valid ? 32'(rd_sel) : '0;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

endmodule

@@ hdl/wffh_chk.sv @@
`include "web_flow_feature_histogram_top_defines.svh"

// Port-level checks on the flow feature histogram.
module wffh_chk import wffh_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pkt_valid,
	input logic      pkt_ready,
	input logic      res_valid,
	input logic      res_ready,
	input wffh_out_t res_payload
);

	// A stalled result stays on the port unchanged.
	`WFFH_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_payload), "result changed while stalled")

	// The input side only backs up when a result is waiting at the output.
	`WFFH_ASSERT_IMPLY(a_ready_backpressure, !pkt_ready, res_valid && !res_ready, "input stalled without output stall")

	// A time bin is only bumped together with an accepted segment and its size bin.
	`WFFH_ASSERT_IMPLY(a_time_bin_acc, res_valid && (res_payload.time_bin != TIME_NONE), res_payload.accepted && (res_payload.size_bin != SIZE_NONE), "time bin without accepted segment")

	// Read data only comes with a result that bumped nothing.
	`WFFH_ASSERT_IMPLY(a_read_clean, res_valid && (res_payload.read_data != '0), !res_payload.accepted && !res_payload.direction && (res_payload.size_bin == SIZE_NONE) && (res_payload.time_bin == TIME_NONE), "read data on a packet result")

	// With no result waiting at the output, an offered input is always taken.
	`WFFH_ASSERT_IMPLY(a_accept_not_blocked, pkt_valid && !res_valid, pkt_ready, "input refused with empty output")

endmodule

bind web_flow_feature_histogram_top wffh_chk u_wffh_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.pkt_valid   (pkt.valid),
	.pkt_ready   (pkt.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_payload (res.payload)
);

@@ dv/tb_web_flow_feature_histogram_top.sv @@
module tb_web_flow_feature_histogram_top;
	import wffh_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int NUM_PHASES = 5;
	localparam int LONG_SEG_PKTS = 16;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Exclusive upper bounds of the size and gap bins, in bytes and microseconds.
	localparam logic [31:0] LEN_LIMITS [21] = '{
		50, 100, 150, 200, 300, 400, 500, 600, 700, 800, 900, 1000,
		1200, 1400, 1600, 1800, 2000, 3000, 4000, 5000, 10000
	};
	localparam ts_t GAP_LIMITS [8] = '{
		48'd10000, 48'd50000, 48'd100000, 48'd200000,
		48'd500000, 48'd1000000, 48'd2500000, 48'd5000000
	};
	// Spread of the time step between generated packets.
	localparam int STEP_LIMITS [9] = '{
		10000, 50000, 100000, 200000, 500000, 1000000, 2500000, 5000000, 6500000
	};

	typedef struct {
		wffh_in_t  stim;
		bit        typed;
		wffh_out_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	wffh_cfg_if cfg_if ();
	wffh_in_if  pkt_if ();
	wffh_out_if res_if ();

	web_flow_feature_histogram_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.pkt    (pkt_if),
		.res    (res_if)
	);

	// Flow state mirrored by the predictor.
	logic [31:0] group_lim;
	logic [31:0] resp_lim;
	seg_state_t  seg_st [2];
	logic [31:0] seg_len [2];
	cnt_t        flow_counts [NUM_COUNTERS];
	conn_state_t conn;
	ts_t         asked_us;
	ts_t         responded_us;
	ts_t         last_query_us;

	wffh_out_t awaited_features [$];
	dir_row_t  directed_rows [$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        no_gaps = 1'b0;
	int        holds_asked = 0;
	int        holds_done = 0;
	int        hold_left = 0;
	ts_t       wall_us;
	logic      last_up = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Give up on a run that stops making progress.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL web_flow_feature_histogram_top");
			$finish;
		end
	end

	function automatic void flow_clear();
		foreach (seg_st[i]) begin
			seg_st[i] = SEG_EMPTY;
			seg_len[i] = '0;
		end
		foreach (flow_counts[i]) begin
			flow_counts[i] = '0;
		end
		conn = CS_NONE;
		asked_us = '0;
		responded_us = '0;
		last_query_us = '0;
	endfunction

	function automatic void count_bump(input int idx);
		if (flow_counts[idx] != '1) begin
			flow_counts[idx] = flow_counts[idx] + 1'b1;
		end
	endfunction

	// Gap bin 0..7, or 8 when the gap is too long to be binned.
	function automatic int gap_bin(input logic neg, input ts_t gap);
		if (neg) begin
			return 0;
		end
		for (int i = 0; i < 8; i++) begin
			if (gap < GAP_LIMITS[i]) begin
				return i;
			end
		end
		return 8;
	endfunction

	function automatic ts_t ts_mean(input ts_t a, input ts_t b);
		logic [TIMESTAMP_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIMESTAMP_WIDTH:1];
	endfunction

	// Advance the mirrored flow state by one transaction and return its result.
	function automatic wffh_out_t flow_features_after(input wffh_in_t it);
		wffh_out_t r;
		logic up;
		logic take;
		logic finish;
		logic neg;
		int d;
		int b;
		logic [32:0] sum;
		ts_t ts;
		ts_t gap;
		r = '0;
		r.size_bin = SIZE_NONE;
		r.time_bin = TIME_NONE;
		ts = it.timestamp_us;
		case (it.command)
			CMD_READ: begin
				if (it.counter_index < NUM_COUNTERS) begin
					r.read_data = flow_counts[it.counter_index];
				end
			end
			CMD_CLEAR: begin
				flow_clear();
			end
			CMD_PACKET: begin
				up = it.src_port > it.dst_port;
				d = up ? 1 : 0;
				r.direction = up;
				if (it.payload_len != 0) begin
					// Segment length sticks at all ones instead of wrapping.
					sum = {1'b0, seg_len[d]} + it.payload_len;
					seg_len[d] = sum[32] ? '1 : sum[31:0];
					take = 1'b0;
					finish = 1'b0;
					case (seg_st[d])
						SEG_EMPTY: begin
							if (it.tls_app_start) begin
								seg_st[d] = SEG_TLS;
								take = it.push_req;
							end else begin
								seg_st[d] = SEG_SKIP;
							end
						end
						SEG_TLS: begin
							take = it.push_req;
						end
						default: begin
							finish = it.push_req;
						end
					endcase
					if (take) begin
						r.accepted = 1'b1;
						count_bump(d * DIR_STRIDE);
						// Asking/responding machine.
						case (conn)
							CS_ASK: begin
								if (up) begin
									if (ts > asked_us && ts - asked_us > group_lim) begin
										asked_us = ts;
									end else begin
										asked_us = ts_mean(asked_us, ts);
									end
								end else begin
									if (last_query_us != 0) begin
										neg = asked_us < last_query_us;
										gap = neg ? '0 : asked_us - last_query_us;
										if (neg || gap < group_lim) begin
											b = gap_bin(neg, gap);
											if (b < 8) begin
												count_bump(DIR_STRIDE + OFF_TIME_FIRST + b);
												r.time_bin = 5'(b);
											end
										end
									end
									last_query_us = asked_us;
									conn = CS_RESP;
									responded_us = ts;
								end
							end
							CS_RESP: begin
								if (!up) begin
									if (ts < responded_us || ts - responded_us < resp_lim) begin
										responded_us = ts_mean(responded_us, ts);
									end
								end else begin
									neg = responded_us < asked_us;
									gap = neg ? '0 : responded_us - asked_us;
									if (neg || gap < resp_lim) begin
										b = gap_bin(neg, gap);
										if (b < 8) begin
											count_bump(OFF_TIME_FIRST + b);
											r.time_bin = 5'(TIME_BINS + b);
										end
									end
									conn = CS_ASK;
									asked_us = ts;
								end
							end
							default: begin
								if (up) begin
									asked_us = ts;
									conn = CS_ASK;
								end else begin
									responded_us = ts;
									conn = CS_RESP;
								end
							end
						endcase
						// Size bin of the finished segment.
						b = 21;
						for (int i = 0; i < 21 && b == 21; i++) begin
							if (seg_len[d] < LEN_LIMITS[i]) begin
								b = i;
							end
						end
						count_bump(d * DIR_STRIDE + OFF_SIZE_FIRST + b);
						r.size_bin = 5'(b);
						finish = 1'b1;
					end
					if (finish) begin
						seg_len[d] = '0;
						seg_st[d] = SEG_EMPTY;
					end
				end
			end
			default: begin
			end
		endcase
		r.conn_state = conn;
		return r;
	endfunction

	function automatic wffh_in_t mk_pkt(input logic [15:0] src, input logic [15:0] dst,
			input logic [15:0] len, input logic psh, input logic tls, input ts_t ts);
		wffh_in_t it;
		it = '0;
		it.command = CMD_PACKET;
		it.src_port = src;
		it.dst_port = dst;
		it.payload_len = len;
		it.push_req = psh;
		it.tls_app_start = tls;
		it.timestamp_us = ts;
		it.counter_index = 6'h2A;
		return it;
	endfunction

	// Non-packet command with every packet field set, to show that they are ignored.
	function automatic wffh_in_t mk_cmd(input logic [1:0] c, input logic [5:0] idx);
		wffh_in_t it;
		it = mk_pkt(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b1, '1);
		it.command = c;
		it.counter_index = idx;
		return it;
	endfunction

	function automatic wffh_out_t mk_res(input logic acc, input logic dir,
			input logic [4:0] sb, input logic [4:0] tb, input conn_state_t cs,
			input logic [31:0] rd);
		wffh_out_t r;
		r.accepted = acc;
		r.direction = dir;
		r.size_bin = sb;
		r.time_bin = tb;
		r.conn_state = cs;
		r.read_data = rd;
		return r;
	endfunction

	task automatic add_row(input wffh_in_t stim, input bit typed, input wffh_out_t want);
		dir_row_t row;
		row.stim = stim;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Random transaction: mostly well-formed traffic of one flow, the rest noise.
	function automatic wffh_in_t flow_item();
		wffh_in_t it;
		int pick;
		int tier;
		logic go_up;
		logic [15:0] pa;
		logic [15:0] pb;
		it.command = CMD_PACKET;
		it.src_port = 16'($urandom);
		it.dst_port = 16'($urandom);
		it.payload_len = 16'($urandom);
		it.push_req = 1'($urandom);
		it.tls_app_start = 1'($urandom);
		it.timestamp_us = {16'($urandom), 32'($urandom)};
		it.counter_index = 6'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			it.command = CMD_READ;
		end else if (pick < 12) begin
			it.command = CMD_CLEAR;
		end else if (pick < 15) begin
			it.command = CMD_UNUSED;
		end else if (pick >= 20) begin
			go_up = ($urandom_range(99) < 60) ? !last_up : last_up;
			pa = 16'($urandom);
			pb = 16'($urandom);
			if (pa == pb) begin
				pb = ~pa;
			end
			if (go_up) begin
				it.src_port = (pa > pb) ? pa : pb;
				it.dst_port = (pa > pb) ? pb : pa;
			end else begin
				it.src_port = (pa > pb) ? pb : pa;
				it.dst_port = (pa > pb) ? pa : pb;
			end
			case ($urandom_range(9))
				0, 1, 2, 3: it.payload_len = 16'($urandom_range(1, 1000));
				4, 5: it.payload_len = 16'($urandom_range(1000, 12000));
				6: it.payload_len = 16'($urandom_range(0, 65535));
				7: it.payload_len = 16'($urandom_range(1, 60));
				default: it.payload_len = 16'($urandom_range(0, 300));
			endcase
			it.push_req = ($urandom_range(99) < 65);
			it.tls_app_start = ($urandom_range(99) < 85);
			// Time mostly moves forward by steps that spread over all gap bins.
			tier = $urandom_range(11);
			if (tier < 9) begin
				wall_us = wall_us + ts_t'($urandom_range(0, STEP_LIMITS[tier]));
			end else if (tier == 9) begin
				wall_us = wall_us - ts_t'($urandom_range(0, 200000));
			end else begin
				wall_us = wall_us + ts_t'($urandom_range(0, 20000));
			end
			it.timestamp_us = wall_us;
			last_up = go_up;
		end
		return it;
	endfunction

	// Offer one transaction, then record what it must produce once accepted.
	task automatic pkt_send(input wffh_in_t it, input bit typed, input wffh_out_t want);
		wffh_out_t predicted;
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 27) begin
			pkt_if.valid <= 1'b0;
			@(negedge clk);
		end
		pkt_if.valid <= 1'b1;
		pkt_if.payload <= it;
		do @(posedge clk); while (!pkt_if.ready);
		predicted = flow_features_after(it);
		awaited_features.push_back(typed ? want : predicted);
	endtask

	// Register write, only once every pending result has come back.
	task automatic reg_write(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		pkt_if.valid <= 1'b0;
		while (awaited_features.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == REG_GROUP_TIME) begin
			group_lim = val;
		end else begin
			resp_lim = val;
		end
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Result receiver: random back-pressure, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			res_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_asked != holds_done) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= no_gaps || ($urandom_range(99) >= 27);
		end
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin : res_check
		wffh_out_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (awaited_features.size() == 0) begin
				$display("%0t: result with no expectation: %h", $time, res_if.payload);
				fail_count++;
			end else begin
				want = awaited_features.pop_front();
				field_check("accepted", 32'(want.accepted), 32'(res_if.payload.accepted));
				field_check("direction", 32'(want.direction), 32'(res_if.payload.direction));
				field_check("size_bin", 32'(want.size_bin), 32'(res_if.payload.size_bin));
				field_check("time_bin", 32'(want.time_bin), 32'(res_if.payload.time_bin));
				field_check("conn_state", 32'(want.conn_state),
					32'(res_if.payload.conn_state));
				field_check("read_data", want.read_data, res_if.payload.read_data);
			end
		end
	end

	initial begin : stimulus
		wffh_in_t it;
		wffh_out_t idle_res;
		int counted;
		bit held;
		logic [31:0] group_set [NUM_PHASES];
		logic [31:0] resp_set [NUM_PHASES];

		arst_n = 1'b0;
		pkt_if.valid = 1'b0;
		pkt_if.payload = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		group_lim = GROUP_TIME_RESET;
		resp_lim = RESPONSE_TIME_RESET;
		flow_clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: reset state, ignored inputs, extremes and time corner cases.
		idle_res = mk_res(1'b0, 1'b0, SIZE_NONE, TIME_NONE, CS_NONE, 32'd0);
		add_row(mk_cmd(CMD_READ, 6'd0), 1'b1, idle_res);
		add_row(mk_cmd(CMD_READ, 6'd63), 1'b1, idle_res);
		add_row(mk_cmd(CMD_UNUSED, 6'd62), 1'b1, idle_res);
		add_row(mk_pkt(16'd50000, 16'd443, 16'd0, 1'b1, 1'b1, 48'h123), 1'b1,
			mk_res(1'b0, 1'b1, SIZE_NONE, TIME_NONE, CS_NONE, 32'd0));
		// Equal ports count as down; a non-TLS start is skipped even with PSH.
		add_row(mk_pkt(16'd443, 16'd443, 16'd100, 1'b1, 1'b0, 48'd7), 1'b1, idle_res);
		add_row(mk_pkt(16'd443, 16'd50000, 16'd10, 1'b1, 1'b0, 48'd8), 1'b1, idle_res);
		add_row(mk_pkt(16'hFFFF, 16'd0, 16'd1, 1'b1, 1'b1, 48'd1000000), 1'b1,
			mk_res(1'b1, 1'b1, 5'd0, TIME_NONE, CS_ASK, 32'd0));
		add_row(mk_pkt(16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 48'd1005000), 1'b1,
			mk_res(1'b1, 1'b0, 5'd21, TIME_NONE, CS_RESP, 32'd0));
		add_row(mk_pkt(16'd50000, 16'd443, 16'd99, 1'b1, 1'b1, 48'd1020000), 1'b0, idle_res);
		add_row(mk_pkt(16'd443, 16'd50000, 16'd10000, 1'b1, 1'b1, 48'd1030000), 1'b0, idle_res);
		// Time runs backward, then forward past a large asked time.
		add_row(mk_pkt(16'd443, 16'd50000, 16'd9999, 1'b1, 1'b1, 48'd0), 1'b0, idle_res);
		add_row(mk_pkt(16'd50000, 16'd443, 16'd50, 1'b1, 1'b1, 48'd2000000), 1'b0, idle_res);
		add_row(mk_pkt(16'd50000, 16'd443, 16'd49, 1'b1, 1'b1, '1), 1'b0, idle_res);
		add_row(mk_pkt(16'd443, 16'd50000, 16'd200, 1'b1, 1'b1, 48'd1000000), 1'b0, idle_res);
		add_row(mk_pkt(16'd50000, 16'd443, 16'd150, 1'b1, 1'b1, 48'd3000000), 1'b0, idle_res);
		add_row(mk_pkt(16'd443, 16'd50000, 16'd300, 1'b1, 1'b1, 48'd3100000), 1'b0, idle_res);
		// A TLS segment spread over two packets.
		add_row(mk_pkt(16'd50000, 16'd443, 16'd600, 1'b0, 1'b1, 48'd3200000), 1'b0, idle_res);
		add_row(mk_pkt(16'd50000, 16'd443, 16'd700, 1'b1, 1'b0, 48'd3300000), 1'b0, idle_res);
		add_row(mk_cmd(CMD_READ, 6'd31), 1'b0, idle_res);
		add_row(mk_cmd(CMD_READ, 6'd23), 1'b0, idle_res);
		add_row(mk_cmd(CMD_READ, 6'd61), 1'b0, idle_res);
		add_row(mk_cmd(CMD_CLEAR, 6'd0), 1'b1, idle_res);
		add_row(mk_cmd(CMD_READ, 6'd32), 1'b1, idle_res);
		foreach (directed_rows[i]) begin
			pkt_send(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		end

		// Random part over several register settings, extremes included.
		group_set = '{GROUP_TIME_RESET, 32'd0, 32'hFFFF_FFFF,
			32'($urandom_range(1000, 3000000)), GROUP_TIME_RESET};
		resp_set = '{RESPONSE_TIME_RESET, 32'd0, 32'hFFFF_FFFF,
			32'($urandom_range(1000, 3000000)), RESPONSE_TIME_RESET};
		held = 1'b0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				reg_write(REG_GROUP_TIME, group_set[ph]);
				reg_write(REG_RESPONSE_TIME, resp_set[ph]);
			end
			wall_us = ts_t'({$urandom, $urandom});
			no_gaps = (ph == 2);
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				it = flow_item();
				pkt_send(it, 1'b0, idle_res);
				if (!(it.command == CMD_UNUSED
						|| (it.command == CMD_PACKET && it.payload_len == 0))) begin
					counted++;
				end
				// One long receiver hold-off while packets keep coming.
				if (ph == 1 && counted >= 40 && !held) begin
					held = 1'b1;
					holds_asked++;
				end
			end
		end
		no_gaps = 1'b0;

		// One down TLS segment spread over many packets, then a closing byte with PSH.
		pkt_send(mk_cmd(CMD_CLEAR, 6'd0), 1'b0, idle_res);
		it = mk_pkt(16'd443, 16'd50000, 16'hFFFF, 1'b0, 1'b1, wall_us);
		pkt_send(it, 1'b0, idle_res);
		for (int n = 0; n < LONG_SEG_PKTS; n++) begin
			it.tls_app_start = 1'($urandom);
			it.timestamp_us = it.timestamp_us + 1'b1;
			pkt_send(it, 1'b0, idle_res);
		end
		pkt_send(mk_pkt(16'd443, 16'd50000, 16'd1, 1'b1, 1'b0, wall_us), 1'b1,
			mk_res(1'b1, 1'b0, 5'd21, TIME_NONE, CS_RESP, 32'd0));

		// Drain and report.
		@(negedge clk);
		pkt_if.valid <= 1'b0;
		while (awaited_features.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS web_flow_feature_histogram_top");
		end else begin
			$display("FAIL web_flow_feature_histogram_top");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/wffh_pkg.sv
hdl/wffh_cfg_if.sv
hdl/wffh_in_if.sv
hdl/wffh_out_if.sv
hdl/wffh_ram.sv
hdl/wffh_flow.sv
hdl/web_flow_feature_histogram_top.sv
hdl/wffh_chk.sv
dv/tb_web_flow_feature_histogram_top.sv
